// ----- rtl/spd_pkg.sv -----
package spd_pkg;

    localparam int PAYLOAD_DEPTH = 32;

    // Even and odd decoded bytes live in separate memories so that both bytes
    // of a word come out in the same cycle; each memory holds two frame banks.
    localparam int HALF_DEPTH = (PAYLOAD_DEPTH + 1) / 2;
    localparam int HALF_AW    = $clog2(HALF_DEPTH);
    localparam int RAM_AW     = HALF_AW + 1;
    localparam int RAM_DEPTH  = 1 << RAM_AW;

    localparam int END_BIT = 7;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_CHECKSUM  = 2'd1;
    localparam logic [1:0] ST_HEADER    = 2'd2;
    localparam logic [1:0] ST_LENGTH    = 2'd3;

    localparam logic KIND_INERTIAL   = 1'b0;
    localparam logic KIND_QUATERNION = 1'b1;

    localparam logic [7:0] INERTIAL_LEN   = 8'd20;
    localparam logic [7:0] QUATERNION_LEN = 8'd10;

    localparam logic [3:0] INERTIAL_WORDS   = 4'd9;
    localparam logic [3:0] QUATERNION_WORDS = 4'd4;
    localparam logic [3:0] GYRO_WORDS       = 4'd3;

    localparam logic [3:0] FRAC_GYRO      = 4'd4;
    localparam logic [3:0] FRAC_ACCEL_MAG = 4'd11;
    localparam logic [3:0] FRAC_QUAT      = 4'd15;

    localparam logic CFG_INERTIAL_CODE   = 1'b0;
    localparam logic CFG_QUATERNION_CODE = 1'b1;

    typedef struct packed {
        logic [1:0] status;
        logic       kind;
        logic       bank;
    } t_job;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr_odd;
        logic [RAM_AW-1:0] addr_even;
    } t_rd_req;

endpackage

// ----- rtl/seven_bit_framed_sensor_packet_decoder.sv -----
// Decodes a stream of 7-bit-per-byte framed sensor packets into signed 16-bit
// words. One received byte is taken per cycle; a byte with bit 7 set ends the
// frame; once that byte is taken with the output side idle, the results come
// through the job slot, memory read and output register: nine words for an
// inertial packet, four for a quaternion packet, or one error result, at one
// result per cycle while the output is ready. Decoded bytes go into two small
// memories (even and odd byte positions) split into two frame banks, so a new
// frame fills one bank while the previous one is read out of the other. The
// input holds off only while one finished frame is being read out and another
// finished frame waits behind it, so the sustained rate is one byte per cycle
// as long as the output drains at least one result per cycle. Header codes are
// to be written only while the block is idle; the block does not enforce this.
module seven_bit_framed_sensor_packet_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_addr,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_rx_byte,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_status,
    output logic                o_packet_kind,
    output logic [3:0]          o_word_index,
    output logic signed [15:0]  o_word_value,
    output logic [3:0]          o_fraction_bits,
    output logic                o_last_flag
);

    logic [7:0] r_inert_code, r_quat_code;

    logic [6:0] r_acc, n_acc;
    logic [2:0] r_pcnt, n_pcnt;
    logic [7:0] r_count, n_count;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_prev, n_prev;
    logic [7:0] r_header, n_header;
    logic       r_bank;

    logic              w_accept, w_has_dec, w_end, w_pend_full;
    logic              w_wr_en;
    logic [13:0]       w_wide;
    logic [2:0]        w_sh;
    logic [7:0]        w_dec;
    logic [6:0]        w_mask;
    logic [spd_pkg::RAM_AW-1:0] w_wr_addr;
    spd_pkg::t_job     w_job;
    spd_pkg::t_rd_req  w_rd;
    logic [7:0]        w_rd_odd, w_rd_even;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inert_code <= 8'd9;
            r_quat_code  <= 8'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                spd_pkg::CFG_INERTIAL_CODE:   r_inert_code <= i_cfg_data;
                spd_pkg::CFG_QUATERNION_CODE: r_quat_code  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_ready = !w_pend_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_end      = w_accept && i_rx_byte[spd_pkg::END_BIT];

    // bit packer: a decoded byte falls out whenever pending bits plus seven reach eight
    always_comb begin
        w_wide    = {r_acc, i_rx_byte[6:0]};
        w_has_dec = (r_pcnt != 3'd0);
        w_sh      = r_pcnt - 3'd1;
        w_dec     = 8'(w_wide >> w_sh);
        w_mask    = (7'd1 << w_sh) - 7'd1;

        n_acc    = w_has_dec ? (w_wide[6:0] & w_mask) : i_rx_byte[6:0];
        n_pcnt   = w_has_dec ? w_sh : 3'd7;
        n_count  = r_count;
        n_sum    = r_sum;
        n_prev   = r_prev;
        n_header = r_header;
        if (w_has_dec) begin
            if (r_count != 8'hFF) begin
                n_count = r_count + 8'd1;
            end
            if (r_count != 8'd0) begin
                n_sum = r_sum + r_prev;
            end
            n_prev = w_dec;
            if (r_count == 8'd0) begin
                n_header = w_dec;
            end
        end

        w_wr_en   = w_accept && w_has_dec && (32'(r_count) < spd_pkg::PAYLOAD_DEPTH);
        w_wr_addr = {r_bank, r_count[spd_pkg::HALF_AW:1]};
    end

    // checksum first, then header, then length
    always_comb begin
        w_job.bank = r_bank;
        w_job.kind = spd_pkg::KIND_INERTIAL;
        if (n_count == 8'd0 || n_sum != n_prev) begin
            w_job.status = spd_pkg::ST_CHECKSUM;
        end else if (n_header == r_inert_code) begin
            w_job.status = (n_count == spd_pkg::INERTIAL_LEN) ? spd_pkg::ST_OK
                                                              : spd_pkg::ST_LENGTH;
        end else if (n_header == r_quat_code) begin
            if (n_count == spd_pkg::QUATERNION_LEN) begin
                w_job.status = spd_pkg::ST_OK;
                w_job.kind   = spd_pkg::KIND_QUATERNION;
            end else begin
                w_job.status = spd_pkg::ST_LENGTH;
            end
        end else begin
            w_job.status = spd_pkg::ST_HEADER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= 7'd0;
            r_pcnt  <= 3'd0;
            r_count <= 8'd0;
            r_sum   <= 8'd0;
            r_prev  <= 8'd0;
            r_bank  <= 1'b0;
        end else if (w_end) begin
            // drop leftover bits and start a fresh frame in the other bank
            r_acc   <= 7'd0;
            r_pcnt  <= 3'd0;
            r_count <= 8'd0;
            r_sum   <= 8'd0;
            r_prev  <= 8'd0;
            r_bank  <= !r_bank;
        end else if (w_accept) begin
            r_acc   <= n_acc;
            r_pcnt  <= n_pcnt;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_prev  <= n_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_header <= n_header;
        end
    end

    spd_ram #(
        .WIDTH(8),
        .DEPTH(spd_pkg::RAM_DEPTH)
    ) u_ram_even (
        .i_clk  (i_clk),
        .i_we   (w_wr_en && !r_count[0]),
        .i_waddr(w_wr_addr),
        .i_wdata(w_dec),
        .i_re   (w_rd.en),
        .i_raddr(w_rd.addr_even),
        .o_rdata(w_rd_even)
    );

    spd_ram #(
        .WIDTH(8),
        .DEPTH(spd_pkg::RAM_DEPTH)
    ) u_ram_odd (
        .i_clk  (i_clk),
        .i_we   (w_wr_en && r_count[0]),
        .i_waddr(w_wr_addr),
        .i_wdata(w_dec),
        .i_re   (w_rd.en),
        .i_raddr(w_rd.addr_odd),
        .o_rdata(w_rd_odd)
    );

    spd_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (w_end),
        .i_job          (w_job),
        .o_pend_full    (w_pend_full),
        .o_rd           (w_rd),
        .i_rd_odd       (w_rd_odd),
        .i_rd_even      (w_rd_even),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_packet_kind  (o_packet_kind),
        .o_word_index   (o_word_index),
        .o_word_value   (o_word_value),
        .o_fraction_bits(o_fraction_bits),
        .o_last_flag    (o_last_flag)
    );

    a_bank_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr_en && w_rd.en) |-> (r_bank != w_rd.addr_odd[spd_pkg::RAM_AW-1]))
        else $error("payload write hits the bank being read out");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != spd_pkg::ST_OK) |-> o_last_flag)
        else $error("error result without last flag");

    a_empty_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 8'd0) |-> (r_sum == 8'd0 && r_prev == 8'd0))
        else $error("running sum nonzero with no decoded bytes");

endmodule

// ----- rtl/spd_ram.sv -----
module spd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/spd_emit.sv -----
module spd_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    input  spd_pkg::t_job        i_job,
    output logic                 o_pend_full,
    output spd_pkg::t_rd_req     o_rd,
    input  logic [7:0]           i_rd_odd,
    input  logic [7:0]           i_rd_even,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_status,
    output logic                 o_packet_kind,
    output logic [3:0]           o_word_index,
    output logic signed [15:0]   o_word_value,
    output logic [3:0]           o_fraction_bits,
    output logic                 o_last_flag
);

    typedef struct packed {
        logic [1:0] status;
        logic       kind;
        logic [3:0] idx;
        logic [3:0] frac;
        logic       last;
    } t_meta;

    logic          r_busy, n_busy;
    spd_pkg::t_job r_act, n_act;
    logic          r_pend_v, n_pend_v;
    spd_pkg::t_job r_pend, n_pend;
    logic [3:0]    r_k, n_k;
    logic          r_s1_v, n_s1_v;
    t_meta         r_s1, n_s1;
    logic          r_out_v, n_out_v;
    t_meta         r_out, n_out;
    logic [15:0]   r_word, n_word;

    logic          w_adv_out, w_mv_s1, w_issue, w_last, w_ok, w_done, w_free;
    logic [3:0]    w_words, w_k_next;
    t_meta         w_meta;

    always_comb begin
        w_ok      = (r_act.status == spd_pkg::ST_OK);
        w_words   = (r_act.kind == spd_pkg::KIND_QUATERNION) ? spd_pkg::QUATERNION_WORDS
                                                             : spd_pkg::INERTIAL_WORDS;
        w_last    = !w_ok || (r_k == w_words - 4'd1);
        w_adv_out = !r_out_v || i_out_ready;
        w_mv_s1   = r_s1_v && w_adv_out;
        w_issue   = r_busy && (!r_s1_v || w_adv_out);
        w_done    = w_issue && w_last;
        w_free    = !r_busy || w_done;
        w_k_next  = r_k + 4'd1;

        w_meta.status = r_act.status;
        w_meta.kind   = w_ok ? r_act.kind : spd_pkg::KIND_INERTIAL;
        w_meta.idx    = w_ok ? r_k : 4'd0;
        w_meta.last   = w_last;
        if (!w_ok) begin
            w_meta.frac = 4'd0;
        end else if (r_act.kind == spd_pkg::KIND_QUATERNION) begin
            w_meta.frac = spd_pkg::FRAC_QUAT;
        end else if (r_k < spd_pkg::GYRO_WORDS) begin
            w_meta.frac = spd_pkg::FRAC_GYRO;
        end else begin
            w_meta.frac = spd_pkg::FRAC_ACCEL_MAG;
        end

        // word k is decoded bytes 1+2k (odd memory, row k) and 2+2k (even memory, row k+1)
        o_rd.en        = w_issue && w_ok;
        o_rd.addr_odd  = {r_act.bank, spd_pkg::HALF_AW'(r_k)};
        o_rd.addr_even = {r_act.bank, spd_pkg::HALF_AW'(w_k_next)};
    end

    // job slots: the active one being read out and one waiting behind it
    always_comb begin
        n_busy   = r_busy;
        n_act    = r_act;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_k      = r_k;
        if (w_issue) begin
            n_k = w_last ? 4'd0 : w_k_next;
        end
        if (w_free) begin
            if (r_pend_v) begin
                n_busy   = 1'b1;
                n_act    = r_pend;
                n_pend_v = i_job_valid;
                n_pend   = i_job;
            end else if (i_job_valid) begin
                n_busy = 1'b1;
                n_act  = i_job;
            end else begin
                n_busy = 1'b0;
            end
        end else if (i_job_valid) begin
            n_pend_v = 1'b1;
            n_pend   = i_job;
        end
    end

    always_comb begin
        n_s1_v  = r_s1_v;
        n_s1    = r_s1;
        n_out_v = r_out_v;
        n_out   = r_out;
        n_word  = r_word;
        if (w_issue) begin
            n_s1_v = 1'b1;
            n_s1   = w_meta;
        end else if (w_mv_s1) begin
            n_s1_v = 1'b0;
        end
        if (w_mv_s1) begin
            n_out_v = 1'b1;
            n_out   = r_s1;
            n_word  = (r_s1.status == spd_pkg::ST_OK) ? {i_rd_odd, i_rd_even} : 16'd0;
        end else if (i_out_ready) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pend_v <= 1'b0;
            r_k      <= 4'd0;
            r_s1_v   <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_pend_v <= n_pend_v;
            r_k      <= n_k;
            r_s1_v   <= n_s1_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act  <= n_act;
        r_pend <= n_pend;
        r_s1   <= n_s1;
        r_out  <= n_out;
        r_word <= n_word;
    end

    assign o_pend_full     = r_pend_v;
    assign o_out_valid     = r_out_v;
    assign o_status        = r_out.status;
    assign o_packet_kind   = r_out.kind;
    assign o_word_index    = r_out.idx;
    assign o_word_value    = signed'(r_word);
    assign o_fraction_bits = r_out.frac;
    assign o_last_flag     = r_out.last;

endmodule

// ----- tb/sv/seven_bit_framed_sensor_packet_decoder_tb.sv -----
`timescale 1ns / 1ps

module seven_bit_framed_sensor_packet_decoder_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_OFF_LEN = 400;
    localparam int SAT_LEN      = 257;

    typedef struct packed {
        logic [1:0]  status;
        logic        kind;
        logic [3:0]  idx;
        logic [15:0] value;
        logic [3:0]  frac;
        logic        last;
    } t_word_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [0:0]         i_cfg_addr = spd_pkg::CFG_INERTIAL_CODE;
    logic [7:0]         i_cfg_data = 8'd0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [7:0]         i_rx_byte = 8'd0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [1:0]         o_status;
    logic               o_packet_kind;
    logic [3:0]         o_word_index;
    logic signed [15:0] o_word_value;
    logic [3:0]         o_fraction_bits;
    logic               o_last_flag;

    seven_bit_framed_sensor_packet_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_packet_kind   (o_packet_kind),
        .o_word_index    (o_word_index),
        .o_word_value    (o_word_value),
        .o_fraction_bits (o_fraction_bits),
        .o_last_flag     (o_last_flag)
    );

    // header codes as currently programmed
    logic [7:0] inertial_code = 8'd9;
    logic [7:0] quaternion_code = 8'd10;

    // decoder state mirror
    logic [13:0] acc_bits = '0;
    int          held_count = 0;
    logic [7:0]  decoded_count = '0;
    logic [7:0]  running_sum = '0;
    logic [7:0]  last_decoded = '0;
    logic [7:0]  frame_store [spd_pkg::PAYLOAD_DEPTH];

    logic [7:0]   rx_pending [$];
    logic [7:0]   frame_bytes [$];
    t_word_result expected_words [$];

    int bytes_queued = 0;
    int bytes_accepted = 0;
    int burst_left = 0;
    int gap_left = 0;
    int cycle_count = 0;
    int ready_mode = 0;
    int ready_mode_left = 0;
    int ready_pattern = 0;
    int hold_off_left = 0;
    int hold_off_at = 32'h7fff_ffff;
    bit hold_off_done = 1'b0;
    int input_stall_cycles = 0;
    int mismatch_count = 0;
    int results_checked = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    t_word_result got_word;
    t_word_result want_word;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Track one received byte through the packer; on a frame end, queue the words
    // or the single error result that the frame yields.
    task automatic decode_rx_byte(input logic [7:0] rx);
        int           bits_held;
        int           words;
        logic [7:0]   dbyte;
        logic         kind;
        t_word_result res;
        acc_bits = {acc_bits[6:0], rx[6:0]};
        bits_held = held_count + 7;
        if (bits_held >= 8) begin
            held_count = bits_held - 8;
            dbyte = 8'(acc_bits >> held_count);
            acc_bits = acc_bits & ((14'd1 << held_count) - 14'd1);
            if (decoded_count != 8'd0) running_sum = running_sum + last_decoded;
            last_decoded = dbyte;
            if (decoded_count < spd_pkg::PAYLOAD_DEPTH) frame_store[decoded_count] = dbyte;
            if (decoded_count != 8'd255) decoded_count = decoded_count + 8'd1;
        end else begin
            held_count = bits_held;
        end
        if (rx[spd_pkg::END_BIT]) begin
            res = '0;
            res.last = 1'b1;
            if (decoded_count == 8'd0 || running_sum != last_decoded) begin
                res.status = spd_pkg::ST_CHECKSUM;
                expected_words.push_back(res);
            end else if (frame_store[0] == inertial_code
                         || frame_store[0] == quaternion_code) begin
                // inertial code wins when both codes are equal
                kind = (frame_store[0] == inertial_code) ? spd_pkg::KIND_INERTIAL
                                                         : spd_pkg::KIND_QUATERNION;
                if (decoded_count != ((kind == spd_pkg::KIND_INERTIAL)
                                      ? spd_pkg::INERTIAL_LEN
                                      : spd_pkg::QUATERNION_LEN)) begin
                    res.status = spd_pkg::ST_LENGTH;
                    expected_words.push_back(res);
                end else begin
                    words = (kind == spd_pkg::KIND_INERTIAL) ? spd_pkg::INERTIAL_WORDS
                                                             : spd_pkg::QUATERNION_WORDS;
                    for (int k = 0; k < words; k++) begin
                        res.status = spd_pkg::ST_OK;
                        res.kind   = kind;
                        res.idx    = 4'(k);
                        res.value  = {frame_store[1 + 2 * k], frame_store[2 + 2 * k]};
                        if (kind == spd_pkg::KIND_QUATERNION) res.frac = spd_pkg::FRAC_QUAT;
                        else res.frac = (k < spd_pkg::GYRO_WORDS) ? spd_pkg::FRAC_GYRO
                                                                  : spd_pkg::FRAC_ACCEL_MAG;
                        res.last   = (k == words - 1);
                        expected_words.push_back(res);
                    end
                end
            end else begin
                res.status = spd_pkg::ST_HEADER;
                expected_words.push_back(res);
            end
            acc_bits = '0;
            held_count = 0;
            decoded_count = '0;
            running_sum = '0;
            last_decoded = '0;
        end
    endtask

    // Pack decoded bytes seven bits per received byte, MSB first; pad the tail
    // with random bits and mark the last received byte as the frame end.
    task automatic encode_frame(input logic [7:0] dec [$]);
        bit         bitq [$];
        int         nraw;
        logic [7:0] raw;
        frame_bytes.delete();
        if (dec.size() == 0) begin
            raw = 8'($urandom_range(0, 127));
            raw[spd_pkg::END_BIT] = 1'b1;
            frame_bytes.push_back(raw);
        end else begin
            nraw = (8 * dec.size() + 6) / 7;
            foreach (dec[i]) for (int j = 7; j >= 0; j--) bitq.push_back(dec[i][j]);
            while (bitq.size() < 7 * nraw) bitq.push_back(1'($urandom_range(0, 1)));
            for (int i = 0; i < nraw; i++) begin
                raw[spd_pkg::END_BIT] = (i == nraw - 1);
                for (int j = 0; j < 7; j++) raw[6 - j] = bitq[7 * i + j];
                frame_bytes.push_back(raw);
            end
        end
    endtask

    // n decoded bytes: header, payload, then the checksum byte
    task automatic build_frame(input logic [7:0] hdr, input int n, input bit bad_sum,
                               input bit extremes);
        logic [7:0] dec [$];
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] corner [4];
        corner = '{8'h00, 8'hff, 8'h80, 8'h7f};
        sum = '0;
        for (int i = 0; i < n - 1; i++) begin
            if (i == 0) b = hdr;
            else if (extremes || $urandom_range(0, 3) == 0) b = corner[$urandom_range(0, 3)];
            else b = 8'($urandom_range(0, 255));
            dec.push_back(b);
            sum = sum + b;
        end
        if (n > 0) dec.push_back(bad_sum ? sum + 8'($urandom_range(1, 255)) : sum);
        encode_frame(dec);
    endtask

    task automatic queue_bytes();
        foreach (frame_bytes[i]) rx_pending.push_back(frame_bytes[i]);
        bytes_queued += frame_bytes.size();
    endtask

    task automatic queue_frame(input logic [7:0] hdr, input int n, input bit bad_sum,
                               input bit extremes);
        build_frame(hdr, n, bad_sum, extremes);
        queue_bytes();
    endtask

    task automatic queue_random_frame();
        int         sel;
        int         n;
        int         cut;
        bit         quat;
        logic [7:0] hdr;
        logic [7:0] raw;
        sel = $urandom_range(0, 99);
        quat = $urandom_range(0, 1);
        n = quat ? spd_pkg::QUATERNION_LEN : spd_pkg::INERTIAL_LEN;
        hdr = quat ? quaternion_code : inertial_code;
        if (sel < 40) begin
            queue_frame(inertial_code, spd_pkg::INERTIAL_LEN, 1'b0,
                        $urandom_range(0, 3) == 0);
        end else if (sel < 60) begin
            queue_frame(quaternion_code, spd_pkg::QUATERNION_LEN, 1'b0,
                        $urandom_range(0, 3) == 0);
        end else if (sel < 68) begin
            queue_frame(hdr, n, 1'b1, 1'b0);
        end else if (sel < 74) begin
            cut = $urandom_range(1, 40);
            if (cut == n) cut++;
            queue_frame(hdr, cut, 1'b0, 1'b0);
        end else if (sel < 80) begin
            do hdr = 8'($urandom_range(0, 255));
            while (hdr == inertial_code || hdr == quaternion_code);
            queue_frame(hdr, $urandom_range(2, 24), 1'b0, 1'b0);
        end else if (sel < 84) begin
            queue_frame(8'h00, 0, 1'b0, 1'b0);
        end else if (sel < 92) begin
            // raw noise, may leave a frame open for the next one
            n = $urandom_range(1, 30);
            for (int i = 0; i < n; i++) begin
                raw = 8'($urandom_range(0, 255));
                raw[spd_pkg::END_BIT] = ($urandom_range(0, 7) == 0);
                rx_pending.push_back(raw);
            end
            bytes_queued += n;
        end else begin
            // cut a good frame short with an early end mark
            build_frame(inertial_code, spd_pkg::INERTIAL_LEN, 1'b0, 1'b0);
            cut = $urandom_range(1, frame_bytes.size() - 1);
            frame_bytes = frame_bytes[0:cut - 1];
            frame_bytes[cut - 1][spd_pkg::END_BIT] = 1'b1;
            queue_bytes();
        end
    endtask

    task automatic run_random(input int count);
        int stop;
        stop = bytes_queued + count;
        while (bytes_queued < stop) queue_random_frame();
        // close any frame left open by noise
        queue_frame(8'h00, 0, 1'b0, 1'b0);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (bytes_accepted != bytes_queued || expected_words.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_header_codes(input logic [7:0] ins, input logic [7:0] quat);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= spd_pkg::CFG_INERTIAL_CODE;
        i_cfg_data <= ins;
        @(posedge i_clk);
        i_cfg_addr <= spd_pkg::CFG_QUATERNION_CODE;
        i_cfg_data <= quat;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        inertial_code = ins;
        quaternion_code = quat;
        @(negedge i_clk);
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_rx_byte  <= 8'd0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                decode_rx_byte(i_rx_byte);
                bytes_accepted <= bytes_accepted + 1;
            end
            if (i_in_valid && !o_in_ready) begin
                input_stall_cycles <= input_stall_cycles + 1;
            end else if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (rx_pending.size() > 0) begin
                i_in_valid <= 1'b1;
                i_rx_byte  <= rx_pending.pop_front();
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 48);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern picked at random, plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_off_left > 0) begin
            hold_off_left--;
            i_out_ready <= 1'b0;
        end else if (!hold_off_done && bytes_accepted >= hold_off_at) begin
            hold_off_done = 1'b1;
            hold_off_left = HOLD_OFF_LEN;
            i_out_ready <= 1'b0;
        end else begin
            if (ready_mode_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                ready_mode_left = $urandom_range(16, 96);
            end else begin
                ready_mode_left--;
            end
            ready_pattern = (ready_pattern + 1) % 5;
            case (ready_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 1));
                2: i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= (ready_pattern != 0);
            endcase
        end
    end

    // compare every result transaction with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_word = '{o_status, o_packet_kind, o_word_index, o_word_value,
                         o_fraction_bits, o_last_flag};
            if (expected_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected: st %0d kind %0d idx %0d val %h frac %0d last %0d",
                             got_word.status, got_word.kind, got_word.idx, got_word.value,
                             got_word.frac, got_word.last);
            end else begin
                want_word = expected_words.pop_front();
                results_checked++;
                status_seen[got_word.status]++;
                if (got_word.status !== want_word.status || got_word.kind !== want_word.kind
                    || got_word.idx !== want_word.idx || got_word.value !== want_word.value
                    || got_word.frac !== want_word.frac || got_word.last !== want_word.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch at result %0d:", results_checked);
                        $display("  expected st %0d kind %0d idx %0d val %h frac %0d last %0d",
                                 want_word.status, want_word.kind, want_word.idx,
                                 want_word.value, want_word.frac, want_word.last);
                        $display("  got      st %0d kind %0d idx %0d val %h frac %0d last %0d",
                                 got_word.status, got_word.kind, got_word.idx,
                                 got_word.value, got_word.frac, got_word.last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_words.size());
            $display("[seven_bit_framed_sensor_packet_decoder] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // long output hold-off while the directed frames keep coming
        hold_off_at = 30;

        // reset codes: corner bytes, every error kind, both packet types
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'h7f);
        rx_pending.push_back(8'hff);
        bytes_queued += 3;
        queue_frame(8'h00, 0, 1'b0, 1'b0);
        queue_frame(inertial_code, spd_pkg::INERTIAL_LEN, 1'b0, 1'b1);
        queue_frame(quaternion_code, spd_pkg::QUATERNION_LEN, 1'b0, 1'b1);
        queue_frame(inertial_code, spd_pkg::INERTIAL_LEN, 1'b1, 1'b0);
        queue_frame(8'h00, spd_pkg::INERTIAL_LEN, 1'b0, 1'b0);
        queue_frame(inertial_code, spd_pkg::INERTIAL_LEN + 1, 1'b0, 1'b0);
        queue_frame(quaternion_code, spd_pkg::QUATERNION_LEN - 1, 1'b0, 1'b0);
        queue_frame(8'h00, 1, 1'b0, 1'b0);
        // long enough for the decoded count to saturate
        queue_frame(inertial_code, SAT_LEN, 1'b0, 1'b0);
        wait_idle();

        write_header_codes(8'h00, 8'hff);
        queue_frame(8'h00, 1, 1'b0, 1'b0);
        run_random(25);
        wait_idle();

        write_header_codes(8'h5a, 8'h5a);
        queue_frame(8'h5a, spd_pkg::QUATERNION_LEN, 1'b0, 1'b0);
        run_random(25);
        wait_idle();

        write_header_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_random(25);
        wait_idle();

        $display("%0d bytes sent, %0d results: %0d ok, %0d checksum, %0d header, %0d length",
                 bytes_accepted, results_checked, status_seen[spd_pkg::ST_OK],
                 status_seen[spd_pkg::ST_CHECKSUM], status_seen[spd_pkg::ST_HEADER],
                 status_seen[spd_pkg::ST_LENGTH]);
        $display("header code settings: 4, input stalled for %0d cycles, %0d mismatches",
                 input_stall_cycles, mismatch_count);
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("[seven_bit_framed_sensor_packet_decoder] OK");
        end else begin
            $display("%0d expected results never arrived", expected_words.size());
            $display("[seven_bit_framed_sensor_packet_decoder] ERROR");
        end
        $finish;
    end

endmodule
